// File: hdl/qmvn_pkg.sv
// ----------------------------------------------------------------------------
// qmvn_pkg
// Shared types and constants of the quad mesh vertex normal block.
// ----------------------------------------------------------------------------
package qmvn_pkg;

   localparam int IDX_W   = 12;  // vertex index field width
   localparam int WIDE_W  = 17;  // index widened to hold the largest vertex count
   localparam int POS_W   = 24;  // Q7.16 position component
   localparam int EDGE_W  = 25;  // edge component
   localparam int PROD_W  = 50;  // edge product
   localparam int CROSS_W = 51;  // cross product component
   localparam int SUM_W   = 20;  // Q5.14 normal sum component
   localparam int EPS_W   = 16;
   localparam int MAG_W   = 24;  // magnitude limit after pre-shift
   localparam int Q_W     = 50;  // sum of squares
   localparam int LEN_W   = 26;  // root register slice
   localparam int NUM_W   = 41;  // divide remainder
   localparam int QUO_W   = 15;  // quotient, at most one in Q1.14
   localparam int CNT_W   = 4;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_QUAD  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sd524287;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -20'sd524288;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
   localparam logic [QUO_W-1:0] Q14_ONE = 15'd16384;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [IDX_W-1:0]      vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0]      corner_a;
      logic [IDX_W-1:0]      corner_b;
      logic [IDX_W-1:0]      corner_c;
      logic [IDX_W-1:0]      corner_d;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_index;
      logic signed [SUM_W-1:0] normal_x;
      logic signed [SUM_W-1:0] normal_y;
      logic signed [SUM_W-1:0] normal_z;
      logic                    was_normalized;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] x;
      logic signed [CROSS_W-1:0] y;
      logic signed [CROSS_W-1:0] z;
   } cross_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_type;

   // handshake between sequencer and a normalize unit
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
   } unit_sts_type;

endpackage

// File: hdl/qmvn_ram.sv
// ----------------------------------------------------------------------------
// qmvn_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qmvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/qmvn_lane.sv
// ----------------------------------------------------------------------------
// qmvn_lane
// Corner lane: edges to the neighbor corners and their cross product.
// ----------------------------------------------------------------------------
module qmvn_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  qmvn_pkg::pos_type   prev_pos,
   input  qmvn_pkg::pos_type   cur_pos,
   input  qmvn_pkg::pos_type   next_pos,
   output qmvn_pkg::cross_type cross_out,
   output logic                valid
);

   logic signed [qmvn_pkg::EDGE_W-1:0] a_ff [3];
   logic signed [qmvn_pkg::EDGE_W-1:0] b_ff [3];
   logic signed [qmvn_pkg::PROD_W-1:0] p_ff [6];
   qmvn_pkg::cross_type cross_ff;
   logic [2:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= qmvn_pkg::EDGE_W'(prev_pos.x) - qmvn_pkg::EDGE_W'(cur_pos.x);
      a_ff[1] <= qmvn_pkg::EDGE_W'(prev_pos.y) - qmvn_pkg::EDGE_W'(cur_pos.y);
      a_ff[2] <= qmvn_pkg::EDGE_W'(prev_pos.z) - qmvn_pkg::EDGE_W'(cur_pos.z);
      b_ff[0] <= qmvn_pkg::EDGE_W'(next_pos.x) - qmvn_pkg::EDGE_W'(cur_pos.x);
      b_ff[1] <= qmvn_pkg::EDGE_W'(next_pos.y) - qmvn_pkg::EDGE_W'(cur_pos.y);
      b_ff[2] <= qmvn_pkg::EDGE_W'(next_pos.z) - qmvn_pkg::EDGE_W'(cur_pos.z);
      p_ff[0] <= a_ff[1] * b_ff[2];
      p_ff[1] <= a_ff[2] * b_ff[1];
      p_ff[2] <= a_ff[2] * b_ff[0];
      p_ff[3] <= a_ff[0] * b_ff[2];
      p_ff[4] <= a_ff[0] * b_ff[1];
      p_ff[5] <= a_ff[1] * b_ff[0];
      cross_ff.x <= qmvn_pkg::CROSS_W'(p_ff[0]) - qmvn_pkg::CROSS_W'(p_ff[1]);
      cross_ff.y <= qmvn_pkg::CROSS_W'(p_ff[2]) - qmvn_pkg::CROSS_W'(p_ff[3]);
      cross_ff.z <= qmvn_pkg::CROSS_W'(p_ff[4]) - qmvn_pkg::CROSS_W'(p_ff[5]);
   end

   assign cross_out = cross_ff;
   assign valid = vld_ff[2];

endmodule

// File: hdl/qmvn_unitize.sv
// ----------------------------------------------------------------------------
// qmvn_unitize
// Iterative unit-length scaling: pre-shift, sum of squares, bit-pair square
// root, then three restoring divides in parallel, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module qmvn_unitize (
   input  logic                   clock,
   input  logic                   reset,
   input  qmvn_pkg::unit_ctl_type ctl,
   input  qmvn_pkg::cross_type    vec,
   output qmvn_pkg::unit_sts_type sts,
   output qmvn_pkg::sum_type      norm
);

   typedef enum logic [5:0] {
      U_IDLE   = 6'b000001,
      U_SHIFT  = 6'b000010,
      U_SQUARE = 6'b000100,
      U_ROOT   = 6'b001000,
      U_PREP   = 6'b010000,
      U_DIVIDE = 6'b100000
   } ustate_type;

   ustate_type state_ff, state_in;

   logic [qmvn_pkg::CROSS_W-1:0] mag_ff [3];
   logic [2:0]                   neg_ff;
   logic [qmvn_pkg::Q_W-1:0]     rem_ff, root_ff, bit_ff;
   logic [qmvn_pkg::NUM_W-1:0]   drem_ff [3];
   logic [qmvn_pkg::NUM_W-1:0]   dsh_ff;
   logic [qmvn_pkg::QUO_W-1:0]   quo_ff [3];
   logic [qmvn_pkg::CNT_W-1:0]   cnt_ff;
   logic                         len_zero_ff;

   logic signed [qmvn_pkg::CROSS_W-1:0] comp [3];
   logic                                over;
   logic [qmvn_pkg::Q_W-1:0]            trial;
   logic [qmvn_pkg::LEN_W-1:0]          len;

   assign comp[0] = vec.x;
   assign comp[1] = vec.y;
   assign comp[2] = vec.z;
   assign over = (|mag_ff[0][qmvn_pkg::CROSS_W-1:qmvn_pkg::MAG_W])
              | (|mag_ff[1][qmvn_pkg::CROSS_W-1:qmvn_pkg::MAG_W])
              | (|mag_ff[2][qmvn_pkg::CROSS_W-1:qmvn_pkg::MAG_W]);
   assign trial = root_ff + bit_ff;
   assign len = root_ff[qmvn_pkg::LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE:   if (ctl.start) state_in = U_SHIFT;
         U_SHIFT:  if (!over) state_in = U_SQUARE;
         U_SQUARE: state_in = U_ROOT;
         U_ROOT:   if (bit_ff[0]) state_in = U_PREP;
         U_PREP:   state_in = U_DIVIDE;
         U_DIVIDE: if (cnt_ff == '0) state_in = U_IDLE;
         default:  state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= comp[i][qmvn_pkg::CROSS_W-1];
                  mag_ff[i] <= comp[i][qmvn_pkg::CROSS_W-1] ? -comp[i] : comp[i];
               end
            end
         end
         U_SHIFT: begin
            if (over) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         U_SQUARE: begin
            rem_ff <= qmvn_pkg::Q_W'(mag_ff[0][qmvn_pkg::MAG_W-1:0]
                                     * mag_ff[0][qmvn_pkg::MAG_W-1:0])
                    + qmvn_pkg::Q_W'(mag_ff[1][qmvn_pkg::MAG_W-1:0]
                                     * mag_ff[1][qmvn_pkg::MAG_W-1:0])
                    + qmvn_pkg::Q_W'(mag_ff[2][qmvn_pkg::MAG_W-1:0]
                                     * mag_ff[2][qmvn_pkg::MAG_W-1:0]);
            root_ff <= '0;
            bit_ff  <= qmvn_pkg::Q_W'(1) << (qmvn_pkg::Q_W - 2);
         end
         U_ROOT: begin
            if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         U_PREP: begin
            for (int i = 0; i < 3; i++) begin
               drem_ff[i] <= (qmvn_pkg::NUM_W'(mag_ff[i][qmvn_pkg::MAG_W-1:0])
                              << (qmvn_pkg::QUO_W)) + qmvn_pkg::NUM_W'(len);
               quo_ff[i]  <= '0;
            end
            dsh_ff      <= qmvn_pkg::NUM_W'({len, 1'b0}) << (qmvn_pkg::QUO_W - 1);
            cnt_ff      <= qmvn_pkg::CNT_W'(qmvn_pkg::QUO_W - 1);
            len_zero_ff <= (len == '0);
         end
         U_DIVIDE: begin
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[i] >= dsh_ff) begin
                  drem_ff[i] <= drem_ff[i] - dsh_ff;
                  quo_ff[i]  <= {quo_ff[i][qmvn_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  quo_ff[i]  <= {quo_ff[i][qmvn_pkg::QUO_W-2:0], 1'b0};
               end
            end
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   function automatic logic signed [qmvn_pkg::SUM_W-1:0] apply_sign(
      input logic [qmvn_pkg::QUO_W-1:0] q, input logic n, input logic z);
      logic signed [qmvn_pkg::SUM_W-1:0] v;
      v = z ? '0 : $signed(qmvn_pkg::SUM_W'(q));
      return n ? -v : v;
   endfunction

   assign norm.x = apply_sign(quo_ff[0], neg_ff[0], len_zero_ff);
   assign norm.y = apply_sign(quo_ff[1], neg_ff[1], len_zero_ff);
   assign norm.z = apply_sign(quo_ff[2], neg_ff[2], len_zero_ff);
   assign sts.busy = (state_ff != U_IDLE);

endmodule

// File: hdl/quad_mesh_vertex_normals.sv
// ----------------------------------------------------------------------------
// quad_mesh_vertex_normals
// Per-vertex normal accumulation over a quad mesh.
// ----------------------------------------------------------------------------
// After reset the block sweeps all VERTEX_COUNT entries of the normal-sum RAM
// to zero, one entry a cycle, with req_ready low. A vertex write is stored as
// it is accepted. A quad reads its four corner positions through the single
// position RAM port, forms the four corner cross products in four lanes,
// scales them in four normalize units side by side (pre-shift, the 25-step
// square root and the 15-step divide), then read-modify-writes the four sums
// through the single sum RAM port. A read returns the stored sum, scaled
// first in normalize unit 0 when its square exceeds the squared threshold
// set over the csr port. Result words sit in an output register while the
// next word is taken.
module quad_mesh_vertex_normals #(
   parameter int VERTEX_COUNT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  qmvn_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output qmvn_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [qmvn_pkg::EPS_W-1:0]          csr_wr_data
);

   localparam int AW = $clog2(VERTEX_COUNT);
   localparam logic [qmvn_pkg::WIDE_W-1:0] VC = qmvn_pkg::WIDE_W'(VERTEX_COUNT);
   localparam logic [AW-1:0] LAST = AW'(VERTEX_COUNT - 1);

   typedef enum logic [11:0] {
      T_CLEAR  = 12'b000000000001,
      T_IDLE   = 12'b000000000010,
      T_FETCH  = 12'b000000000100,
      T_CROSS  = 12'b000000001000,
      T_UNIT   = 12'b000000010000,
      T_MERGE  = 12'b000000100000,
      T_RFETCH = 12'b000001000000,
      T_RWAIT  = 12'b000010000000,
      T_RSQ    = 12'b000100000000,
      T_RCMP   = 12'b001000000000,
      T_RUNIT  = 12'b010000000000,
      T_ROUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   function automatic logic in_range(input logic [qmvn_pkg::IDX_W-1:0] i);
      return qmvn_pkg::WIDE_W'(i) < VC;
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [qmvn_pkg::IDX_W-1:0] i);
      logic [qmvn_pkg::WIDE_W-1:0] w;
      w = qmvn_pkg::WIDE_W'(i);
      return w[AW-1:0];
   endfunction

   function automatic logic signed [qmvn_pkg::SUM_W-1:0] sat_add(
      input logic signed [qmvn_pkg::SUM_W-1:0] a,
      input logic signed [qmvn_pkg::SUM_W-1:0] b);
      logic signed [qmvn_pkg::SUM_W:0] s;
      s = (qmvn_pkg::SUM_W+1)'(a) + (qmvn_pkg::SUM_W+1)'(b);
      if (s > (qmvn_pkg::SUM_W+1)'(qmvn_pkg::SUM_MAX)) return qmvn_pkg::SUM_MAX;
      if (s < (qmvn_pkg::SUM_W+1)'(qmvn_pkg::SUM_MIN)) return qmvn_pkg::SUM_MIN;
      return s[qmvn_pkg::SUM_W-1:0];
   endfunction

   logic [qmvn_pkg::EPS_W-1:0] eps_ff;
   logic [AW-1:0]              clr_ff;
   logic [AW-1:0]              corner_ff [4];
   logic [2:0]                 fetch_ff;
   logic [2:0]                 merge_ff;
   qmvn_pkg::pos_type          pos_ff [4];
   logic [qmvn_pkg::IDX_W-1:0] rd_idx_ff;
   logic                       rd_ok_ff;
   qmvn_pkg::sum_type          rd_sum_ff;
   logic [qmvn_pkg::Q_W-1:0]   rd_q_ff;
   logic [2*qmvn_pkg::EPS_W-1:0] eps2_ff;
   qmvn_pkg::sum_type          res_ff;
   logic                       res_flag_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   qmvn_pkg::rsp_type          rsp_ff;

   logic accept;
   logic [1:0] mj;

   // RAM ports
   logic                          pos_we, sum_we;
   logic [AW-1:0]                 pos_addr, sum_addr;
   qmvn_pkg::pos_type             pos_wdata, pos_rdata;
   qmvn_pkg::sum_type             sum_wdata, sum_rdata;

   // lanes and normalize units
   logic                          lane_start;
   logic [3:0]                    lane_valid;
   qmvn_pkg::cross_type           lane_cross [4];
   qmvn_pkg::unit_ctl_type        unit_ctl [4];
   qmvn_pkg::unit_sts_type        unit_sts [4];
   qmvn_pkg::cross_type           unit_vec [4];
   qmvn_pkg::sum_type             unit_norm [4];
   logic                          quad_go, rd_go, units_busy;
   qmvn_pkg::cross_type           rd_vec;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == T_IDLE);
   assign mj = merge_ff[2:1];

   qmvn_ram #(.WIDTH($bits(qmvn_pkg::pos_type)), .DEPTH(VERTEX_COUNT)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .addr  (pos_addr),
      .wdata (pos_wdata),
      .rdata (pos_rdata)
   );

   qmvn_ram #(.WIDTH($bits(qmvn_pkg::sum_type)), .DEPTH(VERTEX_COUNT)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .addr  (sum_addr),
      .wdata (sum_wdata),
      .rdata (sum_rdata)
   );

   assign pos_wdata.x = req_data.pos_x;
   assign pos_wdata.y = req_data.pos_y;
   assign pos_wdata.z = req_data.pos_z;

   always_comb begin
      pos_we   = 1'b0;
      pos_addr = corner_ff[fetch_ff[1:0]];
      if (state_ff == T_IDLE) begin
         pos_addr = to_addr(req_data.vertex_index);
         pos_we   = accept && (req_data.opcode == qmvn_pkg::OP_WRITE)
                    && in_range(req_data.vertex_index);
      end
   end

   always_comb begin
      sum_we    = 1'b0;
      sum_addr  = to_addr(rd_idx_ff);
      sum_wdata = '0;
      priority case (1'b1)
         state_ff == T_CLEAR: begin
            sum_we   = 1'b1;
            sum_addr = clr_ff;
         end
         state_ff == T_IDLE: begin
            sum_addr = to_addr(req_data.vertex_index);
            sum_we   = accept && (req_data.opcode == qmvn_pkg::OP_WRITE)
                       && in_range(req_data.vertex_index);
         end
         state_ff == T_MERGE: begin
            sum_addr    = corner_ff[mj];
            sum_we      = merge_ff[0];
            sum_wdata.x = sat_add(sum_rdata.x, unit_norm[mj].x);
            sum_wdata.y = sat_add(sum_rdata.y, unit_norm[mj].y);
            sum_wdata.z = sat_add(sum_rdata.z, unit_norm[mj].z);
         end
         default: ;
      endcase
   end

   // corner lanes: previous, current and next corner in winding order
   assign lane_start = (state_ff == T_FETCH) && (fetch_ff == 3'd5);

   for (genvar l = 0; l < 4; l++) begin : g_lane
      qmvn_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .prev_pos  (pos_ff[(l + 3) % 4]),
         .cur_pos   (pos_ff[l]),
         .next_pos  (pos_ff[(l + 1) % 4]),
         .cross_out (lane_cross[l]),
         .valid     (lane_valid[l])
      );

      qmvn_unitize u_unit (
         .clock (clock),
         .reset (reset),
         .ctl   (unit_ctl[l]),
         .vec   (unit_vec[l]),
         .sts   (unit_sts[l]),
         .norm  (unit_norm[l])
      );
   end

   assign quad_go = (state_ff == T_CROSS) && (&lane_valid);
   assign rd_go   = (state_ff == T_RCMP) && (rd_q_ff > qmvn_pkg::Q_W'(eps2_ff));
   assign rd_vec.x = qmvn_pkg::CROSS_W'(rd_sum_ff.x);
   assign rd_vec.y = qmvn_pkg::CROSS_W'(rd_sum_ff.y);
   assign rd_vec.z = qmvn_pkg::CROSS_W'(rd_sum_ff.z);

   // unit 0 is shared with the read path
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         unit_ctl[l].start = quad_go;
         unit_vec[l]       = lane_cross[l];
      end
      unit_ctl[0].start = quad_go || rd_go;
      if (state_ff == T_RCMP) unit_vec[0] = rd_vec;
   end

   assign units_busy = unit_sts[0].busy | unit_sts[1].busy
                     | unit_sts[2].busy | unit_sts[3].busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_CLEAR: if (clr_ff == LAST) state_in = T_IDLE;
         T_IDLE: begin
            if (accept) begin
               if (req_data.opcode == qmvn_pkg::OP_QUAD) begin
                  if (in_range(req_data.corner_a) && in_range(req_data.corner_b)
                      && in_range(req_data.corner_c) && in_range(req_data.corner_d))
                     state_in = T_FETCH;
               end else if (req_data.opcode == qmvn_pkg::OP_READ) begin
                  state_in = T_RFETCH;
               end
            end
         end
         T_FETCH:  if (lane_start) state_in = T_CROSS;
         T_CROSS:  if (quad_go) state_in = T_UNIT;
         T_UNIT:   if (!units_busy) state_in = T_MERGE;
         T_MERGE:  if (merge_ff == 3'd7) state_in = T_IDLE;
         T_RFETCH: state_in = T_RWAIT;
         T_RWAIT:  state_in = T_RSQ;
         T_RSQ:    state_in = T_RCMP;
         T_RCMP:   state_in = rd_go ? T_RUNIT : T_ROUT;
         T_RUNIT:  if (!unit_sts[0].busy) state_in = T_ROUT;
         T_ROUT:   if (!rsp_valid_ff || rsp_ready) state_in = T_IDLE;
         default:  state_in = T_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == T_ROUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_ff       <= '0;
         eps_ff       <= qmvn_pkg::EPS_RESET;
         rsp_valid_ff <= 1'b0;
         fetch_ff     <= '0;
         merge_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) eps_ff <= csr_wr_data;
         if (state_ff == T_CLEAR) clr_ff <= clr_ff + 1'b1;
         fetch_ff <= (state_ff == T_FETCH) ? fetch_ff + 1'b1 : '0;
         merge_ff <= (state_ff == T_MERGE) ? merge_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         corner_ff[0] <= to_addr(req_data.corner_a);
         corner_ff[1] <= to_addr(req_data.corner_b);
         corner_ff[2] <= to_addr(req_data.corner_c);
         corner_ff[3] <= to_addr(req_data.corner_d);
         rd_idx_ff    <= req_data.vertex_index;
         rd_ok_ff     <= in_range(req_data.vertex_index);
      end
      // RAM data arrives in the cycle after its address
      if (state_ff == T_FETCH && fetch_ff != 3'd0 && fetch_ff != 3'd5) begin
         pos_ff[fetch_ff[1:0] - 2'd1] <= pos_rdata;
      end
      if (state_ff == T_RWAIT) begin
         rd_sum_ff <= rd_ok_ff ? sum_rdata : '0;
      end
      if (state_ff == T_RSQ) begin
         rd_q_ff <= qmvn_pkg::Q_W'(rd_sum_ff.x * rd_sum_ff.x)
                  + qmvn_pkg::Q_W'(rd_sum_ff.y * rd_sum_ff.y)
                  + qmvn_pkg::Q_W'(rd_sum_ff.z * rd_sum_ff.z);
         eps2_ff <= eps_ff * eps_ff;
      end
      if (state_ff == T_RCMP) begin
         res_ff      <= rd_sum_ff;
         res_flag_ff <= 1'b0;
      end
      if (state_ff == T_RUNIT && !unit_sts[0].busy) begin
         res_ff      <= unit_norm[0];
         res_flag_ff <= 1'b1;
      end
      if (state_ff == T_ROUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.out_index      <= rd_idx_ff;
         rsp_ff.normal_x       <= res_ff.x;
         rsp_ff.normal_y       <= res_ff.y;
         rsp_ff.normal_z       <= res_ff.z;
         rsp_ff.was_normalized <= res_flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/qmvn_checker.sv
// ----------------------------------------------------------------------------
// qmvn_checker
// Port-level checks of the vertex normal block, bound to the top level.
// ----------------------------------------------------------------------------
module qmvn_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input qmvn_pkg::rsp_type rsp_data
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word dropped or changed while stalled");

   // right after reset the sum RAM clear keeps the input closed and no word is valid
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block open right after reset");

   // a scaled normal stays within one in Q1.14
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_normalized |->
         rsp_data.normal_x <= 20'sd16384 && rsp_data.normal_x >= -20'sd16384 &&
         rsp_data.normal_y <= 20'sd16384 && rsp_data.normal_y >= -20'sd16384 &&
         rsp_data.normal_z <= 20'sd16384 && rsp_data.normal_z >= -20'sd16384)
      else $error("normalized word out of unit range");

endmodule

bind quad_mesh_vertex_normals qmvn_checker u_qmvn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
